/* design/refcounted_charge_cache_core_macros.svh */
// Assertion macros used by the charge cache top level.
`ifndef REFCOUNTED_CHARGE_CACHE_CORE_MACROS_SVH
`define REFCOUNTED_CHARGE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/rcc_pkg.sv */
// Package with types, sizes and codes of the charge cache.
`timescale 1ns / 1ps
package rcc_pkg;

  localparam int ENTRIES  = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int PTR_W    = IDX_W + 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_BITS = 64;
  localparam int USAGE_W  = 21;
  localparam int REFS_W   = 6;

  localparam logic [PTR_W-1:0]   NIL       = PTR_W'(ENTRIES);
  localparam logic [REFS_W-1:0]  REFS_MAX  = '1;
  localparam logic [USAGE_W-1:0] USAGE_MAX = '1;

  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_LOOKUP  = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_ERASE   = 3'd3;
  localparam logic [2:0] ACT_PRUNE   = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISS       = 2'd1;
  localparam logic [1:0] ST_NO_SLOT    = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  typedef enum logic [2:0] {
    OP_INSERT, OP_LOOKUP, OP_RELEASE, OP_ERASE, OP_PRUNE, OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SCAN, B_EXEC, B_DROP_OLD, B_EVICT, B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         key_hash;
    logic [31:0]         value;
    logic [15:0]         charge;
    logic [4:0]          handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                is_free_notice;
    logic [4:0]          out_handle;
    logic [31:0]         out_value;
    logic [KEY_BITS-1:0] out_key;
    logic [USAGE_W-1:0]  usage;
    logic                last;
  } out_item_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         key_hash;
    logic [31:0]         value;
    logic [15:0]         charge;
    logic [4:0]          handle;
  } cmd_t;

endpackage

/* design/rcc_front.sv */
// Front end: accepts input beats, decodes the action and queues commands.
`timescale 1ns / 1ps
module rcc_front
  import rcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.key      = in_data.key;
    cmd_in.key_hash = in_data.key_hash;
    cmd_in.value    = in_data.value;
    cmd_in.charge   = in_data.charge;
    cmd_in.handle   = in_data.handle;
    case (in_data.action)
      ACT_INSERT:  cmd_in.op = OP_INSERT;
      ACT_LOOKUP:  cmd_in.op = OP_LOOKUP;
      ACT_RELEASE: cmd_in.op = OP_RELEASE;
      ACT_ERASE:   cmd_in.op = OP_ERASE;
      ACT_PRUNE:   cmd_in.op = OP_PRUNE;
      default:     cmd_in.op = OP_QUERY;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cmd_in;
  end

endmodule

/* design/rcc_back.sv */
// Back end: slot store, eviction order, command execution and result output.
`timescale 1ns / 1ps
module rcc_back
  import rcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [USAGE_W-1:0] capacity,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic [ENTRIES-1:0]  used_r, in_cache_r;
  logic [REFS_W-1:0]   refs_r   [ENTRIES];
  logic [KEY_BITS-1:0] key_r    [ENTRIES];
  logic [31:0]         hash_r   [ENTRIES];
  logic [31:0]         value_r  [ENTRIES];
  logic [15:0]         charge_r [ENTRIES];
  logic [PTR_W-1:0]    next_r   [ENTRIES];
  logic [PTR_W-1:0]    prev_r   [ENTRIES];
  logic [PTR_W-1:0]    head_r, tail_r;
  logic [USAGE_W-1:0]  usage_r;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic [IDX_W-1:0] scan_r, found_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] notice_r [ENTRIES];
  logic [CNT_W-1:0] ncnt_r, emit_r;
  logic [1:0]       main_st_r;
  logic [4:0]       main_h_r;
  logic [31:0]      main_v_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic             main_ld;
  logic [1:0]       main_st;
  logic [4:0]       main_h;
  logic [31:0]      main_v;
  logic             scan_hit, free_ok, emit_go, out_can;
  logic [IDX_W-1:0] free_idx;
  logic             lv_en, lk_en, rel_en, alloc_en;
  logic [IDX_W-1:0] lv_idx, rel_idx;
  logic [REFS_W-1:0] lv_newrefs, rel_newrefs;
  logic             lv_free, rel_free, rel_bad;
  logic             unlink_en, push_en, notice_en;
  logic [IDX_W-1:0] unlink_idx, notice_idx, emit_idx;
  logic [PTR_W-1:0] ul_p, ul_n;
  logic [USAGE_W:0] usage_sum;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int s = ENTRIES - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(s);
      end
    end
  end

  assign scan_hit = used_r[scan_r] && in_cache_r[scan_r] &&
                    (hash_r[scan_r] == cmd_r.key_hash) && (key_r[scan_r] == cmd_r.key);

  // Leaving the cache drops the cache's own reference.
  assign lv_newrefs = (refs_r[lv_idx] != '0) ? refs_r[lv_idx] - 1'b1 : '0;
  assign lv_free    = (lv_newrefs == '0);

  assign rel_idx     = cmd_r.handle[IDX_W-1:0];
  assign rel_newrefs = (refs_r[rel_idx] != '0) ? refs_r[rel_idx] - 1'b1 : '0;
  assign rel_free    = (rel_newrefs == '0);
  assign rel_bad     = !used_r[rel_idx] ||
                       (in_cache_r[rel_idx] && refs_r[rel_idx] <= REFS_W'(1));

  assign unlink_en  = (lv_en && refs_r[lv_idx] == REFS_W'(1)) ||
                      (lk_en && refs_r[found_idx_r] == REFS_W'(1));
  assign unlink_idx = lk_en ? found_idx_r : lv_idx;
  assign ul_p       = prev_r[unlink_idx];
  assign ul_n       = next_r[unlink_idx];
  assign push_en    = rel_en && in_cache_r[rel_idx] && (rel_newrefs == REFS_W'(1));
  assign notice_en  = (lv_en && lv_free) || (rel_en && rel_free);
  assign notice_idx = lv_en ? lv_idx : rel_idx;
  assign usage_sum  = {1'b0, usage_r} + (USAGE_W + 1)'(cmd_r.charge);
  assign out_can    = !out_valid_r || out_ready;
  assign emit_idx   = notice_r[emit_r[IDX_W-1:0]];

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    lv_en     = 1'b0;
    lv_idx    = found_idx_r;
    lk_en     = 1'b0;
    rel_en    = 1'b0;
    alloc_en  = 1'b0;
    main_ld   = 1'b0;
    main_st   = ST_OK;
    main_h    = '0;
    main_v    = '0;
    emit_go   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_INSERT || q_cmd.op == OP_LOOKUP || q_cmd.op == OP_ERASE) begin
            state_nxt = B_SCAN;
          end else begin
            state_nxt = B_EXEC;
          end
        end
      end
      B_SCAN: begin
        if (scan_hit || scan_r == IDX_W'(ENTRIES - 1)) state_nxt = B_EXEC;
      end
      B_EXEC: begin
        main_ld   = 1'b1;
        state_nxt = B_EMIT;
        case (cmd_r.op)
          OP_INSERT: begin
            if (!free_ok) begin
              main_st = ST_NO_SLOT;
            end else begin
              alloc_en  = 1'b1;
              main_h    = 5'(free_idx);
              main_v    = cmd_r.value;
              state_nxt = (found_r && capacity != '0) ? B_DROP_OLD : B_EVICT;
            end
          end
          OP_LOOKUP: begin
            if (!found_r || refs_r[found_idx_r] == REFS_MAX) begin
              main_st = ST_MISS;
            end else begin
              lk_en  = 1'b1;
              main_h = 5'(found_idx_r);
              main_v = value_r[found_idx_r];
            end
          end
          OP_RELEASE: begin
            if (rel_bad) main_st = ST_BAD_HANDLE;
            else rel_en = 1'b1;
          end
          OP_ERASE: begin
            if (found_r) lv_en = 1'b1;
            else main_st = ST_MISS;
          end
          OP_PRUNE: state_nxt = B_EVICT;
          default: ;
        endcase
      end
      B_DROP_OLD: begin
        lv_en     = 1'b1;
        state_nxt = B_EVICT;
      end
      B_EVICT: begin
        if (head_r != NIL && (cmd_r.op == OP_PRUNE || usage_r > capacity)) begin
          lv_en  = 1'b1;
          lv_idx = head_r[IDX_W-1:0];
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_can) begin
          emit_go = 1'b1;
          if (emit_r == ncnt_r) state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state, slot marks, order ends and usage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      in_cache_r  <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      usage_r     <= '0;
      ncnt_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        ncnt_r <= '0;
        emit_r <= '0;
      end
      if (alloc_en) begin
        used_r[free_idx]     <= 1'b1;
        in_cache_r[free_idx] <= (capacity != '0);
        if (capacity != '0) usage_r <= usage_sum[USAGE_W] ? USAGE_MAX : usage_sum[USAGE_W-1:0];
      end
      if (lv_en) begin
        in_cache_r[lv_idx] <= 1'b0;
        if (lv_free) used_r[lv_idx] <= 1'b0;
        usage_r <= (USAGE_W'(charge_r[lv_idx]) > usage_r) ? '0
                   : usage_r - USAGE_W'(charge_r[lv_idx]);
      end
      if (rel_en && rel_free) begin
        used_r[rel_idx]     <= 1'b0;
        in_cache_r[rel_idx] <= 1'b0;
      end
      if (notice_en) ncnt_r <= ncnt_r + 1'b1;
      if (unlink_en) begin
        if (ul_p == NIL) head_r <= ul_n;
        if (ul_n == NIL) tail_r <= ul_p;
      end
      if (push_en) begin
        if (tail_r == NIL) head_r <= PTR_W'(rel_idx);
        tail_r <= PTR_W'(rel_idx);
      end
      if (emit_go) begin
        emit_r      <= emit_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot payload, links and per-command registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r   <= q_cmd;
      scan_r  <= '0;
      found_r <= 1'b0;
    end
    if (state_r == B_SCAN) begin
      scan_r <= scan_r + 1'b1;
      if (scan_hit) begin
        found_r     <= 1'b1;
        found_idx_r <= scan_r;
      end
    end
    if (main_ld) begin
      main_st_r <= main_st;
      main_h_r  <= main_h;
      main_v_r  <= main_v;
    end
    if (alloc_en) begin
      key_r[free_idx]    <= cmd_r.key;
      hash_r[free_idx]   <= cmd_r.key_hash;
      value_r[free_idx]  <= cmd_r.value;
      charge_r[free_idx] <= cmd_r.charge;
      refs_r[free_idx]   <= (capacity != '0) ? REFS_W'(2) : REFS_W'(1);
    end
    if (lv_en) refs_r[lv_idx] <= lv_newrefs;
    if (lk_en) refs_r[found_idx_r] <= refs_r[found_idx_r] + 1'b1;
    if (rel_en) refs_r[rel_idx] <= rel_newrefs;
    if (notice_en) notice_r[ncnt_r[IDX_W-1:0]] <= notice_idx;
    if (unlink_en) begin
      if (ul_p != NIL) next_r[ul_p[IDX_W-1:0]] <= ul_n;
      if (ul_n != NIL) prev_r[ul_n[IDX_W-1:0]] <= ul_p;
    end
    if (push_en) begin
      next_r[rel_idx] <= NIL;
      prev_r[rel_idx] <= tail_r;
      if (tail_r != NIL) next_r[tail_r[IDX_W-1:0]] <= PTR_W'(rel_idx);
    end
    if (emit_go) begin
      out_r.usage <= usage_r;
      if (emit_r != ncnt_r) begin
        out_r.status         <= ST_OK;
        out_r.is_free_notice <= 1'b1;
        out_r.out_handle     <= 5'(emit_idx);
        out_r.out_value      <= value_r[emit_idx];
        out_r.out_key        <= key_r[emit_idx];
        out_r.last           <= 1'b0;
      end else begin
        out_r.status         <= main_st_r;
        out_r.is_free_notice <= 1'b0;
        out_r.out_handle     <= main_h_r;
        out_r.out_value      <= main_v_r;
        out_r.out_key        <= '0;
        out_r.last           <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/refcounted_charge_cache_core.sv */
// Top level of the reference-counted cache shard with charge eviction.
`timescale 1ns / 1ps
`include "refcounted_charge_cache_core_macros.svh"
// The block holds 32 entry slots and takes one command beat on the in_ channel:
// insert, lookup, release, erase, prune or usage query. Each command answers
// with zero or more free-notice beats, one per entry freed, followed by one
// main beat with last set. Every beat carries the usage after the command.
// The cfg_ channel writes the capacity; it is always ready and should only be
// written while no command is in flight. A capacity of zero turns caching off.
// A two-deep command queue sits in front, so a new command is taken while the
// previous one runs. The back end works on one command at a time: a scan over
// the slots for insert, lookup and erase (one slot per cycle, ending at the
// first hit), an execute step, eviction or pruning of entries one by one after
// an insert or prune, and then the result beats, one beat at a time.
// The result sits in an output register; when out_ready is low the back end
// holds, the queue fills and in_ready drops. Synchronous reset empties all
// slots, the eviction order, the queue and the capacity.
module refcounted_charge_cache_core
  import rcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [USAGE_W-1:0] cfg_data
);

  logic [USAGE_W-1:0] capacity_r;
  logic               q_valid, q_pop;
  cmd_t               q_cmd;

  assign cfg_ready = 1'b1;

  // The capacity register takes every configuration beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  rcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  rcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The back end only pops a command that the queue really holds.
  `RCC_ASSERT_NOW(a_pop_valid, q_pop, q_valid)
  // A notice beat is never the final beat of a command.
  `RCC_ASSERT_NOW(a_notice_not_last, out_valid && out_data.is_free_notice, !out_data.last)
  // A configuration beat lands in the capacity register.
  `RCC_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, capacity_r == $past(cfg_data))

endmodule
